@@ rtl/ppe_pkg.sv @@
// Shared types and constants for the power-law easing tween generator.
package ppe_pkg;

	localparam int VALUE_W = 16;
	localparam int POWER_W = 3;
	localparam int DIR_W   = 2;
	localparam int INDEX_W = 3;
	localparam int MAX_POW = 5;

	typedef enum logic [DIR_W-1:0] {
		DIR_IN    = 2'd0,
		DIR_OUT   = 2'd1,
		DIR_INOUT = 2'd2
	} ease_dir_t;

	typedef enum logic [INDEX_W-1:0] {
		REG_CURVE_POWER    = 3'd0,
		REG_EASE_DIRECTION = 3'd1,
		REG_START_VALUE    = 3'd2,
		REG_CHANGE_AMOUNT  = 3'd3,
		REG_DURATION_TICKS = 3'd4
	} reg_index_t;

	localparam logic [POWER_W-1:0] POW_MIN = 3'd1;
	localparam logic [POWER_W-1:0] POW_MAX = 3'd5;

endpackage

@@ rtl/polynomial_power_easing.sv @@
// Power-law easing tween generator: pipelined divider, power chain and scaler.
//
// Each input word carries the elapsed ticks of a tween; each output word carries
// start + round(change * f(t/d)) for the configured curve (power 1..5, ease in,
// out or in-out) plus a flag that is set when the elapsed time was beyond the
// duration and was clamped to it. The block takes one word every clock cycle
// and returns one word per input word, in order. The pipe is made of one entry
// stage, FRAC_BITS + 1 stages of a restoring divider that resolve one quotient
// bit each, one stage that folds the time for the chosen direction, five
// multiply stages of the power chain, one stage that unfolds the curve, one
// scaling multiply and the output register. All stages advance together; when
// the output word is not taken, the whole pipe holds. Write configuration only
// while the pipe is empty.
module polynomial_power_easing #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [ppe_pkg::INDEX_W-1:0]           cfg_index,
	input  logic [ppe_pkg::VALUE_W-1:0]           cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [ppe_pkg::VALUE_W-1:0]           elapsed_ticks,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [ppe_pkg::VALUE_W:0]      eased_value,
	output logic                                  time_clamped
);

	localparam int VW  = ppe_pkg::VALUE_W;
	localparam int UW  = FRAC_BITS + 1;          // Q1.F fraction, range [0, ONE]
	localparam int NW  = VW + FRAC_BITS + 1;     // divider remainder width
	localparam int DS  = FRAC_BITS + 1;          // divider stages, one quotient bit each
	localparam int NP  = ppe_pkg::MAX_POW;
	localparam int PW  = VW + UW + 1;            // scaling product width
	localparam logic [UW-1:0] ONE  = UW'(1) << FRAC_BITS;
	localparam logic [UW-1:0] HALF = ONE >> 1;

	// Configuration registers.
	logic [ppe_pkg::POWER_W-1:0] curve_power_q;
	logic [ppe_pkg::DIR_W-1:0]   ease_direction_q;
	logic [VW-1:0]               start_value_q;
	logic [VW-1:0]               change_amount_q;
	logic [VW-1:0]               duration_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_power_q    <= 3'd2;
			ease_direction_q <= ppe_pkg::DIR_IN;
			start_value_q    <= '0;
			change_amount_q  <= '0;
			duration_ticks_q <= VW'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				ppe_pkg::REG_CURVE_POWER:    curve_power_q    <= cfg_data[ppe_pkg::POWER_W-1:0];
				ppe_pkg::REG_EASE_DIRECTION: ease_direction_q <= cfg_data[ppe_pkg::DIR_W-1:0];
				ppe_pkg::REG_START_VALUE:    start_value_q    <= cfg_data;
				ppe_pkg::REG_CHANGE_AMOUNT:  change_amount_q  <= cfg_data;
				ppe_pkg::REG_DURATION_TICKS: duration_ticks_q <= cfg_data;
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

	// Effective settings: zero duration acts as one, power saturates to 1..5,
	// the unused direction code acts as in-out.
	logic [VW-1:0]               d_eff;
	logic [ppe_pkg::POWER_W-1:0] n_eff;
	ppe_pkg::ease_dir_t          dir_eff;

	always_comb begin
		d_eff = (duration_ticks_q == '0) ? VW'(1) : duration_ticks_q;
		if (curve_power_q < ppe_pkg::POW_MIN)
			n_eff = ppe_pkg::POW_MIN;
		else if (curve_power_q > ppe_pkg::POW_MAX)
			n_eff = ppe_pkg::POW_MAX;
		else
			n_eff = curve_power_q;
		unique case (ease_direction_q)
			ppe_pkg::DIR_IN:  dir_eff = ppe_pkg::DIR_IN;
			ppe_pkg::DIR_OUT: dir_eff = ppe_pkg::DIR_OUT;
			default:          dir_eff = ppe_pkg::DIR_INOUT;
		endcase
	end

	// Whole pipe advances when the output register is free or being emptied.
	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// Entry stage: clamp time, form the rounded dividend t*ONE + d/2.
	logic [NW-1:0]  div_rem_s   [0:DS];
	logic [UW-1:0]  div_q_s     [0:DS];
	logic           div_clamp_s [0:DS];
	logic           div_vld_s   [0:DS];
	logic [VW-1:0]  t_clamp;
	logic           t_over;

	assign t_over  = elapsed_ticks > d_eff;
	assign t_clamp = t_over ? d_eff : elapsed_ticks;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			div_vld_s[0] <= 1'b0;
		else if (adv)
			div_vld_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_rem_s[0]   <= NW'({t_clamp, {FRAC_BITS{1'b0}}}) + NW'(d_eff >> 1);
			div_q_s[0]     <= '0;
			div_clamp_s[0] <= t_over;
		end
	end

	// Restoring divider: stage j resolves quotient bit FRAC_BITS - j.
	for (genvar j = 0; j < DS; j++) begin : g_div
		localparam int K = FRAC_BITS - j;
		logic [NW-1:0] dvs;
		logic          take;
		assign dvs  = NW'(d_eff) << K;
		assign take = div_rem_s[j] >= dvs;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				div_vld_s[j+1] <= 1'b0;
			else if (adv)
				div_vld_s[j+1] <= div_vld_s[j];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_rem_s[j+1]    <= take ? div_rem_s[j] - dvs : div_rem_s[j];
				div_q_s[j+1]      <= div_q_s[j] | (take ? (UW'(1) << K) : '0);
				div_clamp_s[j+1]  <= div_clamp_s[j];
			end
		end
	end

	// Fold stage: pick the base of the power for the direction.
	logic [UW-1:0] u_val;
	logic          u_low;
	logic [UW-1:0] x_base;

	assign u_val = (div_q_s[DS] > ONE) ? ONE : div_q_s[DS];
	assign u_low = u_val < HALF;

	always_comb begin
		case (dir_eff)
			ppe_pkg::DIR_IN:  x_base = u_val;
			ppe_pkg::DIR_OUT: x_base = ONE - u_val;
			default:          x_base = u_low ? (u_val << 1) : ((ONE - u_val) << 1);
		endcase
	end

	logic [UW-1:0] pow_acc_s   [0:NP];
	logic [UW-1:0] pow_x_s     [0:NP];
	logic          pow_low_s   [0:NP];
	logic          pow_clamp_s [0:NP];
	logic          pow_vld_s   [0:NP];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pow_vld_s[0] <= 1'b0;
		else if (adv)
			pow_vld_s[0] <= div_vld_s[DS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pow_acc_s[0]   <= ONE;
			pow_x_s[0]     <= x_base;
			pow_low_s[0]   <= u_low;
			pow_clamp_s[0] <= div_clamp_s[DS];
		end
	end

	// Power chain: one rounded product per stage, skipped beyond the power.
	for (genvar i = 0; i < NP; i++) begin : g_pow
		logic [2*UW-1:0] prod;
		logic [UW-1:0]   rnd;
		assign prod = pow_acc_s[i] * pow_x_s[i] + (2*UW)'(HALF);
		assign rnd  = prod[FRAC_BITS +: UW];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				pow_vld_s[i+1] <= 1'b0;
			else if (adv)
				pow_vld_s[i+1] <= pow_vld_s[i];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				pow_acc_s[i+1]   <= (ppe_pkg::POWER_W'(i) < n_eff) ? rnd : pow_acc_s[i];
				pow_x_s[i+1]     <= pow_x_s[i];
				pow_low_s[i+1]   <= pow_low_s[i];
				pow_clamp_s[i+1] <= pow_clamp_s[i];
			end
		end
	end

	// Unfold stage: turn the power into the curve value f.
	logic [UW-1:0] half_acc;
	logic [UW-1:0] f_next;
	logic [UW-1:0] f_s1;
	logic          f_clamp_s1;
	logic          f_vld_s1;

	assign half_acc = UW'(({1'b0, pow_acc_s[NP]} + (UW+1)'(1)) >> 1);

	always_comb begin
		case (dir_eff)
			ppe_pkg::DIR_IN:  f_next = pow_acc_s[NP];
			ppe_pkg::DIR_OUT: f_next = ONE - pow_acc_s[NP];
			default:          f_next = pow_low_s[NP] ? half_acc : ONE - half_acc;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			f_vld_s1 <= 1'b0;
		else if (adv)
			f_vld_s1 <= pow_vld_s[NP];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s1       <= f_next;
			f_clamp_s1 <= pow_clamp_s[NP];
		end
	end

	// Scale stage: change * f + half, floor shift follows.
	logic signed [PW-1:0] mul_s2;
	logic                 mul_clamp_s2;
	logic                 mul_vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mul_vld_s2 <= 1'b0;
		else if (adv)
			mul_vld_s2 <= f_vld_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mul_s2 <= PW'($signed(change_amount_q)) * $signed({1'b0, f_s1})
				+ $signed(PW'(HALF));
			mul_clamp_s2 <= f_clamp_s1;
		end
	end

	// Output register: add the start value to the floored product.
	logic signed [VW:0] scaled;
	assign scaled = mul_s2[FRAC_BITS +: VW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (adv)
			out_valid <= mul_vld_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			eased_value  <= (VW+1)'($signed(start_value_q)) + scaled;
			time_clamped <= mul_clamp_s2;
		end
	end

	// Checks.
	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		div_vld_s[DS] |-> div_q_s[DS] <= ONE)
		else $error("divider quotient above one");

	a_curve_range: assert property (@(posedge clk) disable iff (!arst_n)
		f_vld_s1 |-> f_s1 <= ONE)
		else $error("curve value above one");

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> out_valid && $stable(mul_vld_s2) && $stable(f_vld_s1))
		else $error("pipe moved while output stalled");

	a_feed_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && mul_vld_s2 |=> out_valid)
		else $error("scaled word lost before output");

endmodule
